>>> hw/rtl/psf_pkg.sv
// Shared types and codes for the pair sum finder.
package psf_pkg;

   typedef enum logic [1:0] {
      STATUS_PAIR     = 2'd0,
      STATUS_NO_PAIR  = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   localparam int STATUS_W = 2;

endpackage

>>> hw/rtl/pair_sum_finder.sv
// Streamed two-sum search over a content-addressed set of seen values.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+--------------------------------------
//  req     | in        | req_tvalid / req_tready  | tdata value, tuser first, tlast last
//  rsp     | out       | rsp_tvalid / rsp_tready  | tdata current/partner, tuser status
//  csr     | in        | csr_valid / csr_ready    | csr_wdata target sum
//
// One item per cycle sustained, unless an item with a result finds the result register full and
// rsp_tready low: each item is held in the input register, then the set lookup, the insert and the
// state update finish into the result register, which drives rsp. The result register holds a
// result while rsp_tready is low; an item that makes no result still advances during such a stall.
// Reset clears the control state and target sum; set entries are qualified by the count.
module pair_sum_finder #(
   parameter int SET_DEPTH   = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [((VALUE_WIDTH + 7) / 8) * 8-1:0] req_tdata,   // value
   input  logic                                   req_tuser,   // first_item
   input  logic                                   req_tlast,   // last_item
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [((2 * VALUE_WIDTH + 7) / 8) * 8-1:0] rsp_tdata, // current_value, partner_value
   output logic [psf_pkg::STATUS_W-1:0]           rsp_tuser,   // status
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [VALUE_WIDTH-1:0]                 csr_wdata    // target_sum
);

   localparam int RSP_DATA_W = ((2 * VALUE_WIDTH + 7) / 8) * 8;
   localparam int CNT_W      = $clog2(SET_DEPTH + 1);
   localparam int IDX_W      = $clog2(SET_DEPTH);

   logic signed [VALUE_WIDTH-1:0] target_ff;

   logic                          s1_valid_ff;
   logic signed [VALUE_WIDTH-1:0] s1_value_ff;
   logic                          s1_first_ff;
   logic                          s1_last_ff;

   logic [VALUE_WIDTH-1:0]        entry_ff [SET_DEPTH];
   logic [CNT_W-1:0]              seen_count_ff;
   logic [CNT_W-1:0]              seen_count_in;
   logic                          pair_done_ff;
   logic                          pair_done_in;
   logic                          overflow_ff;
   logic                          overflow_in;

   logic                          rsp_valid_ff;
   psf_pkg::status_type           rsp_status_ff;
   logic [VALUE_WIDTH-1:0]        rsp_current_ff;
   logic [VALUE_WIDTH-1:0]        rsp_partner_ff;
   psf_pkg::status_type           status_in;
   logic [VALUE_WIDTH-1:0]        current_in;
   logic [VALUE_WIDTH-1:0]        partner_in;

   logic signed [VALUE_WIDTH:0]   comp;
   logic                          comp_ok;
   logic [SET_DEPTH-1:0]          comp_hit;
   logic [SET_DEPTH-1:0]          dup_hit;
   logic                          match;
   logic                          dup;
   logic                          do_write;
   logic [VALUE_WIDTH-1:0]        write_value;
   logic [IDX_W-1:0]              write_idx;
   logic                          emit;
   logic                          out_free;
   logic                          advance;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
      end else if (csr_valid) begin
         target_ff <= csr_wdata;
      end
   end

   // lookup against every live entry
   assign comp    = (VALUE_WIDTH + 1)'(target_ff) - (VALUE_WIDTH + 1)'(s1_value_ff);
   assign comp_ok = (comp[VALUE_WIDTH] == comp[VALUE_WIDTH-1]);

   always_comb begin
      for (int i = 0; i < SET_DEPTH; i++) begin
         comp_hit[i] = (CNT_W'(i) < seen_count_ff) && (entry_ff[i] == comp[VALUE_WIDTH-1:0]);
         dup_hit[i]  = (CNT_W'(i) < seen_count_ff) && (entry_ff[i] == s1_value_ff);
      end
   end

   assign match = comp_ok && (|comp_hit);
   assign dup   = |dup_hit;

   always_comb begin
      seen_count_in = seen_count_ff;
      pair_done_in  = pair_done_ff;
      overflow_in   = overflow_ff;
      do_write      = 1'b0;
      write_idx     = seen_count_ff[IDX_W-1:0];
      write_value   = s1_value_ff;
      emit          = 1'b0;
      status_in     = psf_pkg::STATUS_NO_PAIR;
      current_in    = '0;
      partner_in    = '0;
      priority if (s1_first_ff) begin
         seen_count_in = CNT_W'(1);
         pair_done_in  = s1_last_ff;
         overflow_in   = 1'b0;
         do_write      = 1'b1;
         write_idx     = '0;
         emit          = s1_last_ff;
         status_in     = psf_pkg::STATUS_NO_PAIR;
      end else if (pair_done_ff) begin
         emit = 1'b0;
      end else if (match) begin
         pair_done_in = 1'b1;
         emit         = 1'b1;
         status_in    = psf_pkg::STATUS_PAIR;
         current_in   = s1_value_ff;
         partner_in   = comp[VALUE_WIDTH-1:0];
      end else begin
         if (!dup) begin
            if (seen_count_ff < CNT_W'(SET_DEPTH)) begin
               do_write      = 1'b1;
               seen_count_in = seen_count_ff + CNT_W'(1);
            end else begin
               overflow_in = 1'b1;
            end
         end
         if (s1_last_ff) begin
            pair_done_in = 1'b1;
            emit         = 1'b1;
            status_in    = overflow_in ? psf_pkg::STATUS_OVERFLOW : psf_pkg::STATUS_NO_PAIR;
         end
      end
   end

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = s1_valid_ff && (!emit || out_free);
   assign req_tready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         s1_value_ff <= req_tdata[VALUE_WIDTH-1:0];
         s1_first_ff <= req_tuser;
         s1_last_ff  <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_count_ff <= '0;
         pair_done_ff  <= 1'b0;
         overflow_ff   <= 1'b0;
      end else if (advance) begin
         seen_count_ff <= seen_count_in;
         pair_done_ff  <= pair_done_in;
         overflow_ff   <= overflow_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && do_write) begin
         entry_ff[write_idx] <= write_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance && emit) begin
         rsp_status_ff  <= status_in;
         rsp_current_ff <= current_in;
         rsp_partner_ff <= partner_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_partner_ff, rsp_current_ff});

endmodule

>>> test/tb_pair_sum_finder.sv
// Testbench for pair_sum_finder: directed and random arrays checked against a built-in predictor.
`timescale 1ns / 1ps

module tb_pair_sum_finder;

   localparam int SET_DEPTH   = 64;
   localparam int VALUE_WIDTH = 32;
   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 64;
   localparam int CYCLE_LIMIT = 200000;
   localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = 32'sh7fffffff;
   localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = 32'sh80000000;

   typedef struct {
      psf_pkg::status_type            status;
      logic signed [VALUE_WIDTH-1:0] current;
      logic signed [VALUE_WIDTH-1:0] partner;
   } pair_result_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [REQ_DATA_W-1:0]        req_tdata = '0;   // value
   logic                         req_tuser = 1'b0; // first_item
   logic                         req_tlast = 1'b0; // last_item
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]        rsp_tdata;        // current_value, partner_value
   logic [psf_pkg::STATUS_W-1:0] rsp_tuser;        // status
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [VALUE_WIDTH-1:0]       csr_wdata = '0;   // target_sum

   logic signed [VALUE_WIDTH-1:0] seen_set [SET_DEPTH];
   int                            seen_total = 0;
   bit                            array_closed = 1'b0;
   bit                            set_overflowed = 1'b0;
   logic signed [VALUE_WIDTH-1:0] target_reg = '0;
   pair_result_type               expected_results [$];

   int mismatch_count = 0;
   int send_idle_pct  = 0;
   int stall_pct      = 0;
   bit hold_active    = 1'b0;
   int cycle_count    = 0;

   pair_sum_finder #(
      .SET_DEPTH   (SET_DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Regression FAIL");
      $finish;
   end

   always @(negedge clock) begin
      rsp_tready <= hold_active ? 1'b0 : ($urandom_range(99) >= stall_pct);
   end

   task automatic report_mismatch(string what, logic [VALUE_WIDTH-1:0] want,
                                  logic [VALUE_WIDTH-1:0] got);
      $display("%0t mismatch %s: expected %0d got %0d", $realtime, what,
               $signed(want), $signed(got));
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      pair_result_type exp_res;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected item, status", '0, VALUE_WIDTH'(rsp_tuser));
         end else begin
            exp_res = expected_results.pop_front();
            if (rsp_tuser !== exp_res.status)
               report_mismatch("status", VALUE_WIDTH'(exp_res.status), VALUE_WIDTH'(rsp_tuser));
            if (rsp_tdata[31:0] !== exp_res.current)
               report_mismatch("current_value", exp_res.current, rsp_tdata[31:0]);
            if (rsp_tdata[63:32] !== exp_res.partner)
               report_mismatch("partner_value", exp_res.partner, rsp_tdata[63:32]);
         end
      end
   end

   function automatic bit set_holds(logic signed [VALUE_WIDTH-1:0] x);
      for (int i = 0; i < seen_total; i++)
         if (seen_set[i] == x) return 1'b1;
      return 1'b0;
   endfunction

   task automatic predict_pair(logic signed [VALUE_WIDTH-1:0] v, bit first, bit last);
      longint comp;
      if (first) begin
         set_overflowed = 1'b0;
         array_closed   = 1'b0;
         seen_set[0]    = v;
         seen_total     = 1;
      end else begin
         if (array_closed) return;
         comp = longint'(target_reg) - longint'(v);
         if (comp >= longint'(VAL_MIN) && comp <= longint'(VAL_MAX) &&
             set_holds(comp[31:0])) begin
            array_closed = 1'b1;
            expected_results.push_back('{psf_pkg::STATUS_PAIR, v, comp[31:0]});
            return;
         end
         if (!set_holds(v)) begin
            if (seen_total < SET_DEPTH) begin
               seen_set[seen_total] = v;
               seen_total++;
            end else begin
               set_overflowed = 1'b1;
            end
         end
      end
      if (last) begin
         array_closed = 1'b1;
         expected_results.push_back('{set_overflowed ? psf_pkg::STATUS_OVERFLOW
                                                     : psf_pkg::STATUS_NO_PAIR,
                                      '0, '0});
      end
   endtask

   task automatic send_item(logic signed [VALUE_WIDTH-1:0] v, bit first, bit last);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      req_tuser  <= first;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      predict_pair(v, first, last);
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_target(logic signed [VALUE_WIDTH-1:0] sum);
      stop_sending();
      wait_drained();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= sum;
      do @(posedge clock); while (!csr_ready);
      target_reg = sum;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_directed_pairs();
      send_idle_pct = 0;
      stall_pct     = 0;
      write_target(10);
      // open array with an empty set right after reset
      send_item(3, 0, 0);
      send_item(7, 0, 0);
      send_item(1, 0, 1);
      send_item(5, 1, 1);
      send_item(4, 1, 0);
      send_item(4, 0, 0);
      send_item(6, 0, 0);
      send_item(6, 0, 1);
      send_item(5, 1, 0);
      send_item(5, 0, 0);
      send_item(1, 1, 0);
      send_item(2, 0, 0);
      send_item(3, 0, 1);
      send_item(-20, 1, 0);
      send_item(30, 0, 1);
   endtask

   task automatic test_range_edges();
      write_target(VAL_MAX);
      send_item(0, 1, 0);
      send_item(VAL_MAX, 0, 1);
      send_item(VAL_MIN, 1, 0);
      send_item(-1, 0, 0);
      send_item(1, 0, 1);
      write_target(VAL_MIN);
      send_item(VAL_MIN, 1, 0);
      send_item(0, 0, 1);
      send_item(VAL_MAX, 1, 0);
      send_item(1, 0, 1);
      write_target(-1);
      send_item(-1, 1, 0);
      send_item(0, 0, 1);
      send_item(VAL_MIN, 1, 0);
      send_item(VAL_MAX, 0, 1);
      write_target(0);
      send_item(VAL_MIN, 1, 0);
      send_item(VAL_MIN, 0, 1);
   endtask

   task automatic test_store_overflow();
      send_idle_pct = 34;
      stall_pct     = 34;
      write_target(0);
      send_item(1, 1, 0);
      for (int i = 2; i <= SET_DEPTH + 1; i++) send_item(i, 0, 0);
      send_item(-(SET_DEPTH + 1), 0, 0);
      send_item(-3, 0, 1);
      send_item(100, 1, 0);
      for (int i = 101; i <= 170; i++) send_item(i, 0, i == 170);
      send_item(5, 1, 1);
   endtask

   task automatic test_random_traffic(int idle_pct, int stall_in,
                                      logic signed [VALUE_WIDTH-1:0] tgt, int n_items);
      int                            sent;
      int                            len;
      int                            k;
      bit                            drop_last;
      longint                        comp;
      logic signed [VALUE_WIDTH-1:0] v;
      logic signed [VALUE_WIDTH-1:0] history [$];
      write_target(tgt);
      send_idle_pct = idle_pct;
      stall_pct     = stall_in;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(9) == 0) begin
            send_item($urandom, 1'($urandom_range(1)), 1'($urandom_range(1)));
            sent++;
         end else begin
            len       = ($urandom_range(19) == 0) ? $urandom_range(66, 72) : $urandom_range(1, 10);
            drop_last = ($urandom_range(9) == 0);
            history.delete();
            for (int i = 0; i < len; i++) begin
               v = $urandom;
               if (len > SET_DEPTH && i < len - 1) begin
                  v = $urandom;
               end else begin
                  case ($urandom_range(7))
                     0, 1: v = $urandom;
                     2: begin
                        case ($urandom_range(3))
                           0: v = VAL_MIN;
                           1: v = VAL_MAX;
                           2: v = 0;
                           default: v = -1;
                        endcase
                     end
                     3: if (history.size() != 0) v = history[$urandom_range(history.size() - 1)];
                     4, 5: begin
                        if (history.size() != 0) begin
                           k    = $urandom_range(history.size() - 1);
                           comp = longint'(tgt) - longint'(history[k]);
                           if (comp >= longint'(VAL_MIN) && comp <= longint'(VAL_MAX))
                              v = comp[31:0];
                        end
                     end
                     default: v = (tgt >>> 1) + $signed($urandom_range(8)) - 4;
                  endcase
               end
               send_item(v, i == 0, (i == len - 1) && !drop_last);
               history.push_back(v);
               sent++;
            end
         end
      end
   endtask

   task automatic test_backpressure();
      write_target($urandom);
      send_idle_pct = 0;
      stall_pct     = 0;
      fork
         begin
            hold_active = 1'b1;
            repeat (300) @(posedge clock);
            hold_active = 1'b0;
         end
         begin
            for (int i = 0; i < 40; i++) send_item($urandom, 1'b1, 1'b1);
         end
      join
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_pairs();
      test_range_edges();
      test_store_overflow();
      test_random_traffic(0, 0, $urandom, 60);
      test_random_traffic(88, 0, VAL_MAX, 60);
      test_random_traffic(0, 88, VAL_MIN, 60);
      test_random_traffic(34, 34, -1, 60);
      test_backpressure();
      stop_sending();
      stall_pct = 0;
      wait_drained();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
